// File: rtl/slg_pkg.sv
package slg_pkg;

    // Build-time settings
    localparam int LED_COUNT   = 16;
    localparam int SAMPLE_BITS = 12;

    // Field widths
    localparam int SAMPLE_W = 12;
    localparam int THR_W    = 12;
    localparam int CFG_W    = 17;
    localparam int LEVEL_W  = 16;
    localparam int GAUGE_W  = 17;
    localparam int DUTY_W   = 8;
    localparam int LED_W    = 4;
    localparam int CLASS_W  = 2;
    localparam int CIDX_W   = 3;

    // Serial multiplier: gauge times an 8-bit factor, one factor bit per cycle
    localparam int MUL_W  = 8;
    localparam int PROD_W = GAUGE_W + MUL_W;
    localparam int MCNT_W = $clog2(MUL_W);

    // Serial divide by ten, one quotient bit per cycle
    localparam int DIVISOR = 10;
    localparam int DIV_W   = 20;
    localparam int REM_W   = 4;
    localparam int DCNT_W  = $clog2(DIV_W);

    // Fixed-point scale points
    localparam int FULL_SCALE = 65536;
    localparam int LEVEL_MAX  = 65535;
    localparam int FRAC_SHIFT = 4;
    localparam int SCALE_SHIFT = 16;

    // Smoothing weights
    localparam int LVL_OLD_WT  = 6;
    localparam int LVL_NEW_SH  = 6;
    localparam int DUTY_OLD_WT = 9;

    // Register reset values
    localparam logic [THR_W-1:0]  RST_QUIET  = THR_W'(300);
    localparam logic [THR_W-1:0]  RST_ACTIVE = THR_W'(400);
    localparam logic [THR_W-1:0]  RST_LOUD   = THR_W'(600);
    localparam logic [CFG_W-1:0]  RST_SLOW   = CFG_W'(1966);
    localparam logic [CFG_W-1:0]  RST_FAST   = CFG_W'(3932);
    localparam logic [CFG_W-1:0]  RST_DRAIN  = CFG_W'(131);
    localparam logic [DUTY_W-1:0] RST_CEIL   = DUTY_W'(153);

    typedef enum logic [CIDX_W-1:0] {
        CFG_QUIET,
        CFG_ACTIVE,
        CFG_LOUD,
        CFG_SLOW,
        CFG_FAST,
        CFG_DRAIN,
        CFG_CEIL
    } cfg_index_t;

    typedef enum logic [CLASS_W-1:0] {
        CLS_QUIET,
        CLS_BETWEEN,
        CLS_ACTIVE,
        CLS_LOUD
    } loud_class_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LEVEL,
        ST_GAUGE,
        ST_DUTY_MUL,
        ST_DUTY_DIV,
        ST_OUT
    } state_t;

endpackage

// File: rtl/slg_div10.sv
module slg_div10
    import slg_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [DIV_W-1:0] numer,
    output logic             done,
    output logic [DIV_W-1:0] quot
);

    logic [DIV_W-1:0]  numer_reg, numer_next;
    logic [DIV_W-1:0]  quot_reg, quot_next;
    logic [REM_W-1:0]  rem_reg, rem_next;
    logic [DCNT_W-1:0] cnt_reg, cnt_next;
    logic              run_reg, run_next;
    logic              done_reg, done_next;
    logic [REM_W:0]    trial;
    logic [REM_W:0]    diff;
    logic              ge;

    // One restoring step: bring down the next numerator bit
    assign trial = {rem_reg, numer_reg[DIV_W-1]};
    assign ge    = trial >= (REM_W+1)'(DIVISOR);
    assign diff  = trial - (REM_W+1)'(DIVISOR);

    always_comb begin
        numer_next = numer_reg;
        quot_next  = quot_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        run_next   = run_reg;
        done_next  = 1'b0;
        if (start) begin
            numer_next = numer;
            quot_next  = '0;
            rem_next   = '0;
            cnt_next   = '0;
            run_next   = 1'b1;
        end else if (run_reg) begin
            numer_next = {numer_reg[DIV_W-2:0], 1'b0};
            quot_next  = {quot_reg[DIV_W-2:0], ge};
            rem_next   = ge ? diff[REM_W-1:0] : trial[REM_W-1:0];
            cnt_next   = cnt_reg + 1'b1;
            if (cnt_reg == DCNT_W'(DIV_W-1)) begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Shift registers
    always_ff @(posedge aclk) begin
        numer_reg <= numer_next;
        quot_reg  <= quot_next;
        rem_reg   <= rem_next;
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

// File: rtl/slg_mul8.sv
module slg_mul8
    import slg_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [GAUGE_W-1:0] mcand,
    input  logic [MUL_W-1:0]   mplier,
    output logic               done,
    output logic [PROD_W-1:0]  prod
);

    logic [GAUGE_W-1:0] mcand_reg, mcand_next;
    logic [MUL_W-1:0]   mplier_reg, mplier_next;
    logic [PROD_W-1:0]  acc_reg, acc_next;
    logic [MCNT_W-1:0]  cnt_reg, cnt_next;
    logic               run_reg, run_next;
    logic               done_reg, done_next;
    logic [PROD_W-1:0]  addend;

    // Factor bits go MSB first: shift then add
    assign addend = mplier_reg[MUL_W-1] ? PROD_W'(mcand_reg) : '0;

    always_comb begin
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        acc_next    = acc_reg;
        cnt_next    = cnt_reg;
        run_next    = run_reg;
        done_next   = 1'b0;
        if (start) begin
            mcand_next  = mcand;
            mplier_next = mplier;
            acc_next    = '0;
            cnt_next    = '0;
            run_next    = 1'b1;
        end else if (run_reg) begin
            mplier_next = {mplier_reg[MUL_W-2:0], 1'b0};
            acc_next    = {acc_reg[PROD_W-2:0], 1'b0} + addend;
            cnt_next    = cnt_reg + 1'b1;
            if (cnt_reg == MCNT_W'(MUL_W-1)) begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Operands and accumulator
    always_ff @(posedge aclk) begin
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        acc_reg    <= acc_next;
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

// File: rtl/sound_level_gauge.sv
// Channel   | Handshake          | Payload
// ----------+--------------------+---------------------------------------------
// input     | s_valid / s_ready  | s_sound_sample
// result    | m_valid / m_ready  | m_led_step, m_duty_out, m_gauge_out,
//           |                    | m_loudness_class
// config    | cfg_wr_en          | cfg_index, cfg_wdata
//
// One sample at a time: the next sample is taken only once the result of the last
// one has been loaded into the output register. Each sample runs two 20-step
// serial divides by ten (level smoothing, duty smoothing) and two 8-step
// shift-add multiplies, the second overlapped with the duty divide. s_ready is
// high only between samples.
// Reset (aresetn, synchronous, active low) loads the register defaults and
// clears the level, gauge and duty state. A result beat waits in the output
// register while the next sample is taken; a stalled m_ready holds the block
// only when a new result is ready to replace the waiting one.
module sound_level_gauge
    import slg_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,

    input  logic                s_valid,
    output logic                s_ready,
    input  logic [SAMPLE_W-1:0] s_sound_sample,

    output logic                m_valid,
    input  logic                m_ready,
    output logic [LED_W-1:0]    m_led_step,
    output logic [DUTY_W-1:0]   m_duty_out,
    output logic [GAUGE_W-1:0]  m_gauge_out,
    output logic [CLASS_W-1:0]  m_loudness_class,

    input  logic                cfg_wr_en,
    input  logic [CIDX_W-1:0]   cfg_index,
    input  logic [CFG_W-1:0]    cfg_wdata
);

    // Configuration registers
    logic [THR_W-1:0]  quiet_reg, active_reg, loud_reg;
    logic [CFG_W-1:0]  slow_reg, fast_reg, drain_reg;
    logic [DUTY_W-1:0] ceil_reg;

    // Running state
    logic [LEVEL_W-1:0] level_reg, level_next;
    logic [GAUGE_W-1:0] gauge_reg, gauge_next;
    logic [DUTY_W-1:0]  duty_reg;
    loud_class_t        class_reg, class_next;

    state_t state_reg, state_next;

    logic               div_start, div_done, div_src_duty;
    logic [DIV_W-1:0]   div_numer, div_quot;
    logic               mul_start, mul_done, mul_src_led;
    logic [GAUGE_W-1:0] mul_mcand;
    logic [MUL_W-1:0]   mul_mplier;
    logic [PROD_W-1:0]  mul_prod;
    logic               out_load;
    logic               m_valid_reg, m_valid_next;

    logic [SAMPLE_W-1:0] sample_mask;
    logic [DIV_W-1:0]    lvl_numer, duty_numer;
    logic [LEVEL_W-1:0]  thr_quiet, thr_active, thr_loud;
    logic [GAUGE_W:0]    add_sum;
    logic [CFG_W-1:0]    add_step;

    // Register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            quiet_reg  <= RST_QUIET;
            active_reg <= RST_ACTIVE;
            loud_reg   <= RST_LOUD;
            slow_reg   <= RST_SLOW;
            fast_reg   <= RST_FAST;
            drain_reg  <= RST_DRAIN;
            ceil_reg   <= RST_CEIL;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_QUIET:  quiet_reg  <= cfg_wdata[THR_W-1:0];
                CFG_ACTIVE: active_reg <= cfg_wdata[THR_W-1:0];
                CFG_LOUD:   loud_reg   <= cfg_wdata[THR_W-1:0];
                CFG_SLOW:   slow_reg   <= cfg_wdata;
                CFG_FAST:   fast_reg   <= cfg_wdata;
                CFG_DRAIN:  drain_reg  <= cfg_wdata;
                CFG_CEIL:   ceil_reg   <= cfg_wdata[DUTY_W-1:0];
                default: ;
            endcase
        end
    end

    // Divider numerators: 6*level + 64*sample, and 9*duty + raw duty
    assign sample_mask = SAMPLE_W'((32'd1 << SAMPLE_BITS) - 32'd1);
    assign lvl_numer   = (DIV_W'(level_reg) * DIV_W'(LVL_OLD_WT))
                       + (DIV_W'(s_sound_sample & sample_mask) << LVL_NEW_SH);
    assign duty_numer  = (DIV_W'(duty_reg) * DIV_W'(DUTY_OLD_WT))
                       + DIV_W'(mul_prod[SCALE_SHIFT +: DUTY_W]);
    assign div_numer   = div_src_duty ? duty_numer : lvl_numer;

    // Level saturates at full 16 bits
    assign level_next = (div_quot > DIV_W'(LEVEL_MAX)) ? LEVEL_W'(LEVEL_MAX)
                                                       : div_quot[LEVEL_W-1:0];

    // Classification, quiet first, then loud, then active
    assign thr_quiet  = LEVEL_W'(quiet_reg)  << FRAC_SHIFT;
    assign thr_active = LEVEL_W'(active_reg) << FRAC_SHIFT;
    assign thr_loud   = LEVEL_W'(loud_reg)   << FRAC_SHIFT;

    always_comb begin
        priority if (level_reg < thr_quiet) begin
            class_next = CLS_QUIET;
        end else if (level_reg >= thr_loud) begin
            class_next = CLS_LOUD;
        end else if (level_reg >= thr_active) begin
            class_next = CLS_ACTIVE;
        end else begin
            class_next = CLS_BETWEEN;
        end
    end

    // Gauge update with saturation at 0 and full scale
    always_comb begin
        unique case (class_next)
            CLS_LOUD:   add_step = fast_reg;
            CLS_ACTIVE: add_step = slow_reg;
            default:    add_step = slow_reg >> 1;
        endcase
    end

    assign add_sum = (GAUGE_W+1)'(gauge_reg) + (GAUGE_W+1)'(add_step);

    always_comb begin
        if (class_next == CLS_QUIET) begin
            gauge_next = (gauge_reg > drain_reg) ? gauge_reg - drain_reg : '0;
        end else if (add_sum > (GAUGE_W+1)'(FULL_SCALE)) begin
            gauge_next = GAUGE_W'(FULL_SCALE);
        end else begin
            gauge_next = add_sum[GAUGE_W-1:0];
        end
    end

    // Multiplier operands: duty scale first, then LED scale
    assign mul_mcand  = mul_src_led ? gauge_reg : gauge_next;
    assign mul_mplier = mul_src_led ? MUL_W'(LED_COUNT - 1) : ceil_reg;

    slg_div10 u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .numer   (div_numer),
        .done    (div_done),
        .quot    (div_quot)
    );

    slg_mul8 u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .mcand   (mul_mcand),
        .mplier  (mul_mplier),
        .done    (mul_done),
        .prod    (mul_prod)
    );

    // Sequencer: next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:     if (s_valid) state_next = ST_LEVEL;
            ST_LEVEL:    if (div_done) state_next = ST_GAUGE;
            ST_GAUGE:    state_next = ST_DUTY_MUL;
            ST_DUTY_MUL: if (mul_done) state_next = ST_DUTY_DIV;
            ST_DUTY_DIV: if (div_done) state_next = ST_OUT;
            ST_OUT:      if (!m_valid_reg || m_ready) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // Sequencer: outputs
    always_comb begin
        s_ready      = 1'b0;
        div_start    = 1'b0;
        div_src_duty = 1'b0;
        mul_start    = 1'b0;
        mul_src_led  = 1'b0;
        out_load     = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready   = 1'b1;
                div_start = s_valid;
            end
            ST_GAUGE: begin
                mul_start = 1'b1;
            end
            ST_DUTY_MUL: begin
                div_src_duty = 1'b1;
                mul_src_led  = 1'b1;
                div_start    = mul_done;
                mul_start    = mul_done;
            end
            ST_OUT: begin
                out_load = !m_valid_reg || m_ready;
            end
            default: ;
        endcase
    end

    assign m_valid_next = out_load | (m_valid_reg & ~m_ready);

    // Control and running state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            level_reg   <= '0;
            gauge_reg   <= '0;
            duty_reg    <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (state_reg == ST_LEVEL && div_done) begin
                level_reg <= level_next;
            end
            if (state_reg == ST_GAUGE) begin
                gauge_reg <= gauge_next;
            end
            if (state_reg == ST_DUTY_DIV && div_done) begin
                duty_reg <= div_quot[DUTY_W-1:0];
            end
        end
    end

    // Class and output beat registers
    always_ff @(posedge aclk) begin
        if (state_reg == ST_GAUGE) begin
            class_reg <= class_next;
        end
        if (out_load) begin
            m_led_step       <= mul_prod[SCALE_SHIFT +: LED_W];
            m_duty_out       <= duty_reg;
            m_gauge_out      <= gauge_reg;
            m_loudness_class <= class_reg;
        end
    end

    assign m_valid = m_valid_reg;

endmodule
